/* sv/online_linear_fit_time_align_macros.svh */
// assertion macros for the time alignment block
// used by online_linear_fit_time_align.sv, expects clk and rst in scope
`ifndef ONLINE_LINEAR_FIT_TIME_ALIGN_MACROS_SVH
`define ONLINE_LINEAR_FIT_TIME_ALIGN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OLFTA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("olfta check failed");
`define OLFTA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olfta check failed");
`define OLFTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olfta check failed");
`else
`define OLFTA_ASSERT_ALWAYS(lbl, cond)
`define OLFTA_ASSERT_IMPLY(lbl, ante, cons)
`define OLFTA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/olfta_pkg.sv */
// shared types and constants for the time alignment block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package olfta_pkg;

  localparam int TIME_BITS_DEF      = 32;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF     = 16;
  localparam int SLOPE_W            = 48;
  localparam int SLOPE_FRAC         = 32;
  localparam int R2_W               = 33;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_N2B    = 3'd1;
  localparam logic [2:0] KIND_B2N    = 3'd2;
  localparam logic [2:0] KIND_JITTER = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_MXX,
    S_MYY,
    S_MXY,
    S_DXX_A,
    S_DXX_B,
    S_DYY_A,
    S_DYY_B,
    S_DXY_A,
    S_DXY_B,
    S_FLAT_DIV,
    S_SLOPE_DIV,
    S_INT_A,
    S_INT_B,
    S_INT_DEN,
    S_INT_DIV,
    S_R2_A,
    S_R2_DEN,
    S_R2_DIV,
    S_LINE_MUL,
    S_LINE_DIV,
    S_INV_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* sv/olfta_mul.sv */
// bit-serial shift-add multiplier, product modulo 2^W
// depends on olfta_pkg
`timescale 1ns / 1ps
`default_nettype none
module olfta_mul #(
  parameter int W = 228
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic signed [W-1:0]      product,
  output olfta_pkg::unit_stat_t    stat
);

  logic [W-1:0] acc;
  logic [W-1:0] mc;
  logic [W-1:0] mp;
  logic         busy;
  logic         done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (mp == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (mp == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // one multiplier bit per cycle, stops once the remaining bits are zero
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= a;
      mp  <= b;
    end else if (busy && (mp != '0)) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= {mc[W-2:0], 1'b0};
      mp <= {1'b0, mp[W-1:1]};
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

/* sv/olfta_div.sv */
// bit-serial restoring divider, signed, rounds to nearest with ties away from zero
// depends on olfta_pkg
`timescale 1ns / 1ps
`default_nettype none
module olfta_div #(
  parameter int W = 228
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [W-1:0] num,
  input  wire logic signed [W-1:0] den,
  output logic signed [W-1:0]      quotient,
  output olfta_pkg::unit_stat_t    stat
);

  localparam int CW = $clog2(W + 3);

  logic [W-1:0]  an;
  logic [W-1:0]  ad;
  logic [W+1:0]  dvd;
  logic [W+1:0]  d2;
  logic [W:0]    rem;
  logic [W+1:0]  trial;
  logic          ge;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  assign an    = num[W-1] ? $unsigned(-num) : $unsigned(num);
  assign ad    = den[W-1] ? $unsigned(-den) : $unsigned(den);
  assign trial = {rem, dvd[W+1]};
  assign ge    = (trial >= d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W + 2);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // (2|n| + |d|) / (2|d|), one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {1'b0, an, 1'b0} + {2'b00, ad};
      d2  <= {1'b0, ad, 1'b0};
      rem <= '0;
      neg <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      rem <= ge ? (W+1)'(trial - d2) : trial[W:0];
      dvd <= {dvd[W:0], ge};
    end
  end

  assign quotient  = neg ? -$signed(dvd[W-1:0]) : $signed(dvd[W-1:0]);
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

/* sv/online_linear_fit_time_align.sv */
// Running least-squares fit between a neural and a behavioral timebase.
// An add-pair item updates the exact sums and refits intercept, slope and r^2
// through one bit-serial multiplier and one bit-serial divider, both working
// on an internal word of WW = 4*TIME_BITS + 4*COUNT_BITS + 36 bits (228 by
// default) and stepping one bit per cycle. An add pair runs up to 14
// multiplications and 3 divisions. A conversion or jitter item runs one
// multiplication and one division, a behavioral-to-neural item at most one
// division, and clear, reject or unused kinds no unit operation. One item
// is worked at a time; the result register lets the next item be taken
// while a result waits.
// depends on olfta_pkg, olfta_mul, olfta_div and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "online_linear_fit_time_align_macros.svh"
module online_linear_fit_time_align #(
  parameter int TIME_BITS      = olfta_pkg::TIME_BITS_DEF,
  parameter int TIME_FRAC_BITS = olfta_pkg::TIME_FRAC_BITS_DEF,
  parameter int COUNT_BITS     = olfta_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 item_valid,
  output logic                                      item_stall,
  input  wire logic [2:0]                           kind,
  input  wire logic signed [TIME_BITS-1:0]          neural_time,
  input  wire logic signed [TIME_BITS-1:0]          behavioral_time,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic signed [TIME_BITS-1:0]               converted_time,
  output logic signed [TIME_BITS-1:0]               intercept,
  output logic signed [olfta_pkg::SLOPE_W-1:0]      slope,
  output logic [olfta_pkg::R2_W-1:0]                r_squared,
  output logic [COUNT_BITS-1:0]                     pair_count,
  output logic                                      rejected
);

  localparam int TB    = TIME_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int SW    = olfta_pkg::SLOPE_W;
  localparam int SF    = olfta_pkg::SLOPE_FRAC;
  localparam int RW    = olfta_pkg::R2_W;
  localparam int WW    = 4 * TB + 4 * CB + 36;
  localparam int SUM_W = TB + CB;
  localparam int SQ_W  = 2 * TB + CB;

  localparam logic signed [WW-1:0] TMAX_W = {{(WW-TB+1){1'b0}}, {(TB-1){1'b1}}};
  localparam logic signed [WW-1:0] TMIN_W = ~TMAX_W;
  localparam logic signed [WW-1:0] SMAX_W = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN_W = ~SMAX_W;
  localparam logic signed [WW-1:0] R2ONE_W = {{(WW-RW){1'b0}}, 1'b1, {(RW-1){1'b0}}};
  localparam logic signed [WW-1:0] P32_W = {{(WW-SF-1){1'b0}}, 1'b1, {SF{1'b0}}};
  localparam logic signed [WW-1:0] M1_W =
    ~{{(WW-TIME_FRAC_BITS){1'b0}}, {TIME_FRAC_BITS{1'b1}}};
  localparam logic [RW-1:0] R2_ONE = {1'b1, {(RW-1){1'b0}}};
  localparam logic signed [SW-1:0] SLOPE_ONE = {{(SW-SF-1){1'b0}}, 1'b1, {SF{1'b0}}};

  function automatic logic signed [TB-1:0] sat_time(input logic signed [WW-1:0] v);
    if (v > TMAX_W) begin
      return TMAX_W[TB-1:0];
    end else if (v < TMIN_W) begin
      return TMIN_W[TB-1:0];
    end
    return v[TB-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_slope(input logic signed [WW-1:0] v);
    if (v > SMAX_W) begin
      return SMAX_W[SW-1:0];
    end else if (v < SMIN_W) begin
      return SMIN_W[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

  olfta_pkg::state_t state, state_next;

  logic [2:0]               kind_r;
  logic signed [TB-1:0]     x_r;
  logic signed [TB-1:0]     y_r;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [SQ_W-1:0]   sxx, syy, sxy;
  logic [CB-1:0]            n;
  logic signed [TB-1:0]     held_intercept;
  logic signed [SW-1:0]     held_slope;
  logic [RW-1:0]            held_fit_quality;
  logic signed [TB-1:0]     conv;
  logic                     rej;
  logic signed [WW-1:0]     ta, tb, dxx, dyy, dxy;
  logic                     launched;

  logic signed [WW-1:0] x_w, y_w, sx_w, sy_w, sxx_w, syy_w, sxy_w, n_w, int_w, slope_w;
  logic signed [WW-1:0] mul_a, mul_b, mul_p, div_num, div_den, div_q;
  logic                 mul_start, div_start;
  olfta_pkg::unit_stat_t mul_stat, div_stat;
  logic signed [TB-1:0] minus_one;
  logic                 n_full, n_small, out_free, accept;

  assign x_w     = WW'(x_r);
  assign y_w     = WW'(y_r);
  assign sx_w    = WW'(sx);
  assign sy_w    = WW'(sy);
  assign sxx_w   = WW'(sxx);
  assign syy_w   = WW'(syy);
  assign sxy_w   = WW'(sxy);
  assign n_w     = WW'(n);
  assign int_w   = WW'(held_intercept);
  assign slope_w = WW'(held_slope);

  assign minus_one = sat_time(M1_W);
  assign n_full    = (n == '1);
  assign n_small   = (n[CB-1:1] == '0);
  assign out_free  = !result_valid || !result_stall;
  assign item_stall = (state != olfta_pkg::S_IDLE);
  assign accept    = item_valid && !item_stall;

  olfta_mul #(.W(WW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .stat    (mul_stat)
  );

  olfta_div #(.W(WW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      olfta_pkg::S_IDLE: begin
        if (item_valid) state_next = olfta_pkg::S_DISPATCH;
      end
      olfta_pkg::S_DISPATCH: begin
        case (kind_r)
          olfta_pkg::KIND_ADD:    state_next = n_full ? olfta_pkg::S_DONE : olfta_pkg::S_MXX;
          olfta_pkg::KIND_N2B:    state_next = olfta_pkg::S_LINE_MUL;
          olfta_pkg::KIND_JITTER: state_next = olfta_pkg::S_LINE_MUL;
          olfta_pkg::KIND_B2N: begin
            state_next = (held_slope == '0) ? olfta_pkg::S_DONE : olfta_pkg::S_INV_DIV;
          end
          default:                state_next = olfta_pkg::S_DONE;
        endcase
      end
      olfta_pkg::S_MXX:     if (mul_stat.done) state_next = olfta_pkg::S_MYY;
      olfta_pkg::S_MYY:     if (mul_stat.done) state_next = olfta_pkg::S_MXY;
      olfta_pkg::S_MXY:     if (mul_stat.done) state_next = olfta_pkg::S_DXX_A;
      olfta_pkg::S_DXX_A:   if (mul_stat.done) state_next = olfta_pkg::S_DXX_B;
      olfta_pkg::S_DXX_B:   if (mul_stat.done) state_next = olfta_pkg::S_DYY_A;
      olfta_pkg::S_DYY_A:   if (mul_stat.done) state_next = olfta_pkg::S_DYY_B;
      olfta_pkg::S_DYY_B:   if (mul_stat.done) state_next = olfta_pkg::S_DXY_A;
      olfta_pkg::S_DXY_A:   if (mul_stat.done) state_next = olfta_pkg::S_DXY_B;
      olfta_pkg::S_DXY_B: begin
        if (mul_stat.done) begin
          state_next = (dxx == '0) ? olfta_pkg::S_FLAT_DIV : olfta_pkg::S_SLOPE_DIV;
        end
      end
      olfta_pkg::S_FLAT_DIV:  if (div_stat.done) state_next = olfta_pkg::S_DONE;
      olfta_pkg::S_SLOPE_DIV: if (div_stat.done) state_next = olfta_pkg::S_INT_A;
      olfta_pkg::S_INT_A:     if (mul_stat.done) state_next = olfta_pkg::S_INT_B;
      olfta_pkg::S_INT_B:     if (mul_stat.done) state_next = olfta_pkg::S_INT_DEN;
      olfta_pkg::S_INT_DEN:   if (mul_stat.done) state_next = olfta_pkg::S_INT_DIV;
      olfta_pkg::S_INT_DIV: begin
        if (div_stat.done) begin
          state_next = (n_small || dyy == '0) ? olfta_pkg::S_DONE : olfta_pkg::S_R2_A;
        end
      end
      olfta_pkg::S_R2_A:     if (mul_stat.done) state_next = olfta_pkg::S_R2_DEN;
      olfta_pkg::S_R2_DEN:   if (mul_stat.done) state_next = olfta_pkg::S_R2_DIV;
      olfta_pkg::S_R2_DIV:   if (div_stat.done) state_next = olfta_pkg::S_DONE;
      olfta_pkg::S_LINE_MUL: if (mul_stat.done) state_next = olfta_pkg::S_LINE_DIV;
      olfta_pkg::S_LINE_DIV: if (div_stat.done) state_next = olfta_pkg::S_DONE;
      olfta_pkg::S_INV_DIV:  if (div_stat.done) state_next = olfta_pkg::S_DONE;
      olfta_pkg::S_DONE:     if (out_free) state_next = olfta_pkg::S_IDLE;
      default:               state_next = olfta_pkg::S_IDLE;
    endcase
  end

  // unit operands and start requests
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b0;
    div_num   = '0;
    div_den   = P32_W;
    div_start = 1'b0;
    case (state)
      olfta_pkg::S_MXX:      begin mul_a = x_w;     mul_b = x_w;  mul_start = !launched; end
      olfta_pkg::S_MYY:      begin mul_a = y_w;     mul_b = y_w;  mul_start = !launched; end
      olfta_pkg::S_MXY:      begin mul_a = x_w;     mul_b = y_w;  mul_start = !launched; end
      olfta_pkg::S_DXX_A:    begin mul_a = sxx_w;   mul_b = n_w;  mul_start = !launched; end
      olfta_pkg::S_DXX_B:    begin mul_a = sx_w;    mul_b = sx_w; mul_start = !launched; end
      olfta_pkg::S_DYY_A:    begin mul_a = syy_w;   mul_b = n_w;  mul_start = !launched; end
      olfta_pkg::S_DYY_B:    begin mul_a = sy_w;    mul_b = sy_w; mul_start = !launched; end
      olfta_pkg::S_DXY_A:    begin mul_a = sxy_w;   mul_b = n_w;  mul_start = !launched; end
      olfta_pkg::S_DXY_B:    begin mul_a = sx_w;    mul_b = sy_w; mul_start = !launched; end
      olfta_pkg::S_INT_A:    begin mul_a = dxx;     mul_b = sy_w; mul_start = !launched; end
      olfta_pkg::S_INT_B:    begin mul_a = dxy;     mul_b = sx_w; mul_start = !launched; end
      olfta_pkg::S_INT_DEN:  begin mul_a = dxx;     mul_b = n_w;  mul_start = !launched; end
      olfta_pkg::S_R2_A:     begin mul_a = dxy;     mul_b = dxy;  mul_start = !launched; end
      olfta_pkg::S_R2_DEN:   begin mul_a = dxx;     mul_b = dyy;  mul_start = !launched; end
      olfta_pkg::S_LINE_MUL: begin mul_a = slope_w; mul_b = x_w;  mul_start = !launched; end
      olfta_pkg::S_FLAT_DIV: begin
        div_num = sy_w - sx_w; div_den = n_w; div_start = !launched;
      end
      olfta_pkg::S_SLOPE_DIV: begin
        div_num = dxy <<< SF; div_den = dxx; div_start = !launched;
      end
      olfta_pkg::S_INT_DIV:  begin div_num = tb; div_den = ta; div_start = !launched; end
      olfta_pkg::S_R2_DIV:   begin div_num = tb; div_den = ta; div_start = !launched; end
      olfta_pkg::S_LINE_DIV: begin div_num = tb; div_den = P32_W; div_start = !launched; end
      olfta_pkg::S_INV_DIV: begin
        div_num = (y_w - int_w) <<< SF; div_den = slope_w; div_start = !launched;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= olfta_pkg::S_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start || div_start) begin
        launched <= 1'b1;
      end else if (mul_stat.done || div_stat.done) begin
        launched <= 1'b0;
      end
    end
  end

  // fit state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sx               <= '0;
      sy               <= '0;
      sxx              <= '0;
      syy              <= '0;
      sxy              <= '0;
      n                <= '0;
      held_intercept   <= minus_one;
      held_slope       <= '0;
      held_fit_quality <= '0;
    end else begin
      if (accept) begin
        kind_r <= kind;
        x_r    <= neural_time;
        y_r    <= behavioral_time;
        conv   <= '0;
        rej    <= 1'b0;
      end
      case (state)
        olfta_pkg::S_DISPATCH: begin
          case (kind_r)
            olfta_pkg::KIND_ADD: begin
              if (n_full) begin
                rej <= 1'b1;
              end else begin
                n  <= n + CB'(1);
                sx <= sx + SUM_W'(x_r);
                sy <= sy + SUM_W'(y_r);
              end
            end
            olfta_pkg::KIND_B2N: begin
              if (held_slope == '0) conv <= minus_one;
            end
            olfta_pkg::KIND_CLEAR: begin
              sx               <= '0;
              sy               <= '0;
              sxx              <= '0;
              syy              <= '0;
              sxy              <= '0;
              n                <= '0;
              held_intercept   <= minus_one;
              held_slope       <= '0;
              held_fit_quality <= '0;
            end
            default: begin
              conv <= '0;
            end
          endcase
        end
        olfta_pkg::S_MXX:     if (mul_stat.done) sxx <= sxx + SQ_W'(mul_p);
        olfta_pkg::S_MYY:     if (mul_stat.done) syy <= syy + SQ_W'(mul_p);
        olfta_pkg::S_MXY:     if (mul_stat.done) sxy <= sxy + SQ_W'(mul_p);
        olfta_pkg::S_DXX_A:   if (mul_stat.done) ta <= mul_p;
        olfta_pkg::S_DXX_B:   if (mul_stat.done) dxx <= ta - mul_p;
        olfta_pkg::S_DYY_A:   if (mul_stat.done) ta <= mul_p;
        olfta_pkg::S_DYY_B:   if (mul_stat.done) dyy <= ta - mul_p;
        olfta_pkg::S_DXY_A:   if (mul_stat.done) ta <= mul_p;
        olfta_pkg::S_DXY_B:   if (mul_stat.done) dxy <= ta - mul_p;
        olfta_pkg::S_INT_A:   if (mul_stat.done) ta <= mul_p;
        olfta_pkg::S_INT_B:   if (mul_stat.done) tb <= ta - mul_p;
        olfta_pkg::S_INT_DEN: if (mul_stat.done) ta <= mul_p;
        olfta_pkg::S_R2_A:    if (mul_stat.done) tb <= mul_p <<< SF;
        olfta_pkg::S_R2_DEN:  if (mul_stat.done) ta <= mul_p;
        olfta_pkg::S_LINE_MUL: begin
          if (mul_stat.done) begin
            if (kind_r == olfta_pkg::KIND_JITTER) begin
              tb <= (y_w <<< SF) - ((int_w <<< SF) + mul_p);
            end else begin
              tb <= (int_w <<< SF) + mul_p;
            end
          end
        end
        olfta_pkg::S_FLAT_DIV: begin
          // no spread in x: unit slope through the mean offset
          if (div_stat.done) begin
            held_intercept   <= sat_time(div_q);
            held_slope       <= SLOPE_ONE;
            held_fit_quality <= n_small ? '0 : R2_ONE;
          end
        end
        olfta_pkg::S_SLOPE_DIV: if (div_stat.done) held_slope <= sat_slope(div_q);
        olfta_pkg::S_INT_DIV: begin
          if (div_stat.done) begin
            held_intercept <= sat_time(div_q);
            if (n_small || dyy == '0) held_fit_quality <= '0;
          end
        end
        olfta_pkg::S_R2_DIV: begin
          if (div_stat.done) begin
            if (div_q[WW-1]) begin
              held_fit_quality <= '0;
            end else if (div_q > R2ONE_W) begin
              held_fit_quality <= R2_ONE;
            end else begin
              held_fit_quality <= div_q[RW-1:0];
            end
          end
        end
        olfta_pkg::S_LINE_DIV: if (div_stat.done) conv <= sat_time(div_q);
        olfta_pkg::S_INV_DIV:  if (div_stat.done) conv <= sat_time(div_q);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == olfta_pkg::S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == olfta_pkg::S_DONE && out_free) begin
      converted_time <= conv;
      intercept      <= held_intercept;
      slope          <= held_slope;
      r_squared      <= held_fit_quality;
      pair_count     <= n;
      rejected       <= rej;
    end
  end

  `OLFTA_ASSERT_ALWAYS(a_one_unit_busy, !(mul_stat.busy && div_stat.busy))
  `OLFTA_ASSERT_ALWAYS(a_fit_quality_range, held_fit_quality <= R2_ONE)
  `OLFTA_ASSERT_IMPLY(a_reject_only_full, result_valid && rejected, pair_count == '1)
  `OLFTA_ASSERT_NEXT(a_result_loaded, state == olfta_pkg::S_DONE && out_free, result_valid)

endmodule
`default_nettype wire
